// ===== rtl/depth_layer_rle_decoder_top_assert.svh =====
`ifndef DEPTH_LAYER_RLE_DECODER_TOP_ASSERT_SVH
`define DEPTH_LAYER_RLE_DECODER_TOP_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define DLRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that cons holds in the cycle after ante
`define DLRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dlrd_pkg.sv =====
package dlrd_pkg;

    localparam int DEPTH_W = 16;
    localparam int RANK_W  = 4;
    localparam int IDX_W   = 4;
    localparam int LEN_W   = 17;
    localparam int PIX_W   = 24;
    localparam int CODE_W  = 8;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PANEL = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;
    localparam logic [1:0] ST_AFTER_END = 2'd3;

    localparam logic [3:0]       COUNT_ESCAPE = 4'd15;
    localparam logic [LEN_W-1:0] ESC_OFFSET   = 17'd16;
    localparam logic [PIX_W-1:0] PIX_RESET    = 24'd307200;

    typedef struct packed {
        logic clear;
        logic load;
    } cell_ctrl_t;

    typedef struct packed {
        logic [CODE_W-1:0] layer_code;
        logic [LEN_W-1:0]  run_length;
        logic              last_run;
        logic [1:0]        status;
    } result_t;

endpackage

// ===== rtl/dlrd_cell.sv =====
module dlrd_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dlrd_pkg::cell_ctrl_t         ctrl,
    input  logic [dlrd_pkg::DEPTH_W-1:0] value,
    input  logic [dlrd_pkg::RANK_W-1:0]  new_rank,
    input  logic                         prev_valid,
    output logic                         valid,
    output logic                         ge,
    output logic [dlrd_pkg::RANK_W-1:0]  rank
);
    import dlrd_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DEPTH_W-1:0]   depth_next;
    logic [RANK_W-1:0]    rank_reg;
    logic [RANK_W-1:0]    rank_next;
    logic                 below;

    assign below = value < depth_reg;
    assign ge    = valid_reg && !below;
    assign valid = valid_reg;
    assign rank  = rank_reg;

    always_comb
    begin
        valid_next = valid_reg;
        depth_next = depth_reg;
        rank_next  = rank_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            if (valid_reg)
            begin
                if (below)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            else if (prev_valid)
            begin
                valid_next = 1'b1;
                depth_next = value;
                rank_next  = new_rank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        depth_reg <= depth_next;
        rank_reg  <= rank_next;
    end

endmodule

// ===== rtl/depth_layer_rle_decoder_top.sv =====
// Run-length decoder with a ranked depth palette. Words are taken at one per
// clock while in_ready is high: each panel value is ranked in the cell row in
// the cycle it arrives, and each data byte is decoded and clipped against the
// frame size in the same cycle; the result word is registered in the output
// register, or in the one skid stage while the output holds a waiting word,
// so the input keeps flowing; in_ready drops only while the skid stage is
// occupied. Escaped runs take three data bytes and give one result on the last.
module depth_layer_rle_decoder_top #(
    parameter int MAX_PANELS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [dlrd_pkg::PIX_W-1:0]   cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   operation,
    input  logic [dlrd_pkg::DEPTH_W-1:0] item_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dlrd_pkg::CODE_W-1:0]  layer_code,
    output logic [dlrd_pkg::LEN_W-1:0]   run_length,
    output logic                         last_run,
    output logic [1:0]                   status
);
    import dlrd_pkg::*;

    localparam logic [1:0] PH_HEADER     = 2'd0;
    localparam logic [1:0] PH_COUNT_HIGH = 2'd1;
    localparam logic [1:0] PH_COUNT_LOW  = 2'd2;

    logic                  accept;
    logic                  full;
    cell_ctrl_t            cell_ctrl;
    logic [RANK_W-1:0]     new_rank;
    logic [MAX_PANELS-1:0] cell_valid;
    logic [MAX_PANELS-1:0] cell_ge;
    logic [MAX_PANELS-1:0] cell_prev;
    logic [RANK_W-1:0]     cell_rank [MAX_PANELS];

    logic [PIX_W-1:0]      pixel_total_reg;
    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    logic [IDX_W-1:0]      held_index_reg;
    logic [IDX_W-1:0]      held_index_next;
    logic [7:0]            count_high_reg;
    logic [7:0]            count_high_next;
    logic [PIX_W-1:0]      pixels_done_reg;
    logic [PIX_W-1:0]      pixels_done_next;

    logic [7:0]            data_byte;
    logic                  emit;
    logic [IDX_W-1:0]      run_idx;
    logic [LEN_W-1:0]      run_len;
    logic [PIX_W-1:0]      remain;
    logic [LEN_W-1:0]      clipped;
    logic                  hit;
    logic [RANK_W-1:0]     hit_rank;
    logic                  res_fire;
    result_t               res;

    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    result_t               out_reg;
    result_t               skid_reg;
    logic                  out_fire;
    logic                  out_load;
    logic                  skid_load;
    logic                  skid_move;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign full     = cell_valid[MAX_PANELS-1];

    assign cell_ctrl.clear = accept && (operation == OP_START);
    assign cell_ctrl.load  = accept && (operation == OP_PANEL) && !full;

    always_comb
    begin
        new_rank = '0;
        for (int j = 0; j < MAX_PANELS; j++)
        begin
            new_rank = new_rank + RANK_W'(cell_ge[j]);
        end
    end

    assign cell_prev = {cell_valid[MAX_PANELS-2:0], 1'b1};

    for (genvar g = 0; g < MAX_PANELS; g++)
    begin : g_cell
        dlrd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .value      (item_value),
            .new_rank   (new_rank),
            .prev_valid (cell_prev[g]),
            .valid      (cell_valid[g]),
            .ge         (cell_ge[g]),
            .rank       (cell_rank[g])
        );
    end

    assign data_byte = item_value[7:0];

    always_comb
    begin
        hit      = 1'b0;
        hit_rank = '0;
        for (int j = 0; j < MAX_PANELS; j++)
        begin
            if (IDX_W'(j) == run_idx && cell_valid[j])
            begin
                hit      = 1'b1;
                hit_rank = cell_rank[j];
            end
        end
    end

    assign remain  = pixel_total_reg - pixels_done_reg;
    assign clipped = (PIX_W'(run_len) > remain) ? remain[LEN_W-1:0] : run_len;

    always_comb
    begin
        phase_next       = phase_reg;
        held_index_next  = held_index_reg;
        count_high_next  = count_high_reg;
        pixels_done_next = pixels_done_reg;
        emit             = 1'b0;
        run_idx          = data_byte[3:0];
        run_len          = LEN_W'(data_byte[7:4]) + 1'b1;
        res_fire         = 1'b0;
        res              = '0;
        if (accept)
        begin
            case (operation)
                OP_START:
                begin
                    phase_next       = PH_HEADER;
                    held_index_next  = '0;
                    count_high_next  = '0;
                    pixels_done_next = '0;
                end
                OP_PANEL:
                begin
                    if (full)
                    begin
                        res_fire   = 1'b1;
                        res.status = ST_TOO_MANY;
                    end
                end
                OP_DATA:
                begin
                    if (pixels_done_reg >= pixel_total_reg)
                    begin
                        res_fire   = 1'b1;
                        res.status = ST_AFTER_END;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_COUNT_HIGH:
                            begin
                                count_high_next = data_byte;
                                phase_next      = PH_COUNT_LOW;
                            end
                            PH_COUNT_LOW:
                            begin
                                phase_next = PH_HEADER;
                                run_idx    = held_index_reg;
                                run_len    = LEN_W'({count_high_reg, data_byte}) + ESC_OFFSET;
                                emit       = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_HEADER;
                                if (data_byte[7:4] == COUNT_ESCAPE)
                                begin
                                    held_index_next = data_byte[3:0];
                                    phase_next      = PH_COUNT_HIGH;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (emit)
        begin
            pixels_done_next = pixels_done_reg + PIX_W'(clipped);
            res_fire         = 1'b1;
            res.layer_code   = hit ? {hit_rank, 4'b0000} : '0;
            res.run_length   = clipped;
            res.last_run     = (pixels_done_next == pixel_total_reg);
            res.status       = hit ? ST_OK : ST_BAD_INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_total_reg <= PIX_RESET;
            phase_reg       <= PH_HEADER;
            held_index_reg  <= '0;
            count_high_reg  <= '0;
            pixels_done_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pixel_total_reg <= cfg_wr_data;
            end
            phase_reg       <= phase_next;
            held_index_reg  <= held_index_next;
            count_high_reg  <= count_high_next;
            pixels_done_reg <= pixels_done_next;
        end
    end

    assign out_fire  = out_valid_reg && out_ready;
    assign out_load  = res_fire && (!out_valid_reg || out_fire);
    assign skid_load = res_fire && out_valid_reg && !out_fire;
    assign skid_move = !res_fire && out_fire && skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load || skid_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            if (skid_load)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (skid_move)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload words; advance skid into the output when drained
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
        else if (skid_move)
        begin
            out_reg <= skid_reg;
        end
        if (skid_load)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign layer_code = out_reg.layer_code;
    assign run_length = out_reg.run_length;
    assign last_run   = out_reg.last_run;
    assign status     = out_reg.status;

`include "depth_layer_rle_decoder_top_assert.svh"

    `DLRD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    `DLRD_ASSERT_NOW(a_cells_packed, 1'b1, ((cell_valid + 1'b1) & cell_valid) == '0, "panel cells not filled in order")
    `DLRD_ASSERT_NOW(a_last_is_run, out_valid_reg && last_run, run_length != '0 && (status == ST_OK || status == ST_BAD_INDEX), "last flag on a non-run word")
    `DLRD_ASSERT_NEXT(a_frame_start_clears, accept && operation == OP_START, cell_valid == '0 && pixels_done_reg == '0, "frame start did not clear state")

endmodule
